@@ hdl/tfd_pkg.sv @@
// Shared types and constants for the touch frame deframer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package tfd_pkg;

   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;
   localparam int CELL_INDEX_W = 5;

   // Command addresses are 8 bits wide, enough for grids of up to 256 cells.
   localparam int MAX_ADDR_W   = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h12;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h34;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;

   // One command from the front end to the back end: store one word, and
   // optionally start the readout once it is stored.
   typedef struct packed {
      logic                  emit;
      logic [MAX_ADDR_W-1:0] addr;
      logic [WORD_W-1:0]     word;
   } wr_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

`default_nettype wire

@@ hdl/tfd_front.sv @@
// Front end of the deframer: sync hunt, byte pairing, word commands.
// Depends on tfd_pkg; feeds tfd_queue.
`default_nettype none

module tfd_front #(
   parameter int GRID_ROWS = 6,
   parameter int GRID_COLS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [tfd_pkg::BYTE_W-1:0]   req_rx_byte,
   output      logic                         req_stall,
   input  wire tfd_pkg::q_status_type        q_status,
   output      logic                         cmd_push,
   output      tfd_pkg::wr_cmd_type          cmd
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_WAIT    = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;

   logic [1:0]                  phase_ff, phase_in;
   logic                        half_ff, half_in;
   logic [ADDR_W-1:0]           word_cnt_ff, word_cnt_in;
   logic [tfd_pkg::BYTE_W-1:0]  low_ff, low_in;
   logic                        accept;
   logic                        last_word;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign last_word = (word_cnt_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      phase_in    = phase_ff;
      half_in     = half_ff;
      word_cnt_in = word_cnt_ff;
      low_in      = low_ff;
      cmd_push    = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_WAIT: begin
               // a wrong byte keeps waiting, no return to hunting
               if (req_rx_byte == tfd_pkg::SYNC_SECOND) begin
                  phase_in = PH_COLLECT;
               end
            end
            PH_COLLECT: begin
               if (!half_ff) begin
                  low_in  = req_rx_byte;
                  half_in = 1'b1;
               end else begin
                  cmd_push = 1'b1;
                  half_in  = 1'b0;
                  if (last_word) begin
                     word_cnt_in = '0;
                     phase_in    = PH_HUNT;
                  end else begin
                     word_cnt_in = word_cnt_ff + ADDR_W'(1);
                  end
               end
            end
            default: begin
               phase_in = (req_rx_byte == tfd_pkg::SYNC_FIRST) ? PH_WAIT : PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      cmd.emit = last_word;
      cmd.addr = tfd_pkg::MAX_ADDR_W'(word_cnt_ff);
      cmd.word = {req_rx_byte, low_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         half_ff     <= 1'b0;
         word_cnt_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         half_ff     <= half_in;
         word_cnt_ff <= word_cnt_in;
      end
      low_ff <= low_in;
   end

endmodule

`default_nettype wire

@@ hdl/tfd_queue.sv @@
// Short command queue between the front and back ends of the deframer.
// Depends on tfd_pkg for the command type and depth.
`default_nettype none

module tfd_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire tfd_pkg::wr_cmd_type   push_cmd,
   input  wire logic                  pop,
   output      tfd_pkg::wr_cmd_type   head_cmd,
   output      tfd_pkg::q_status_type status
);

   tfd_pkg::wr_cmd_type             entries_ff [tfd_pkg::QUEUE_DEPTH];
   logic [tfd_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tfd_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tfd_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   assign status.full  = (count_ff == tfd_pkg::QCNT_W'(tfd_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + tfd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + tfd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + tfd_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tfd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tfd_pkg::QCNT_W'(tfd_pkg::QUEUE_DEPTH))
      else $error("queue occupancy beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wr_ptr_ff == rd_ptr_ff + count_ff[tfd_pkg::QPTR_W-1:0])
      else $error("queue pointers disagree with occupancy");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into full queue");

endmodule

`default_nettype wire

@@ hdl/tfd_back.sv @@
// Back end of the deframer: word store and transposed readout sequencer.
// Depends on tfd_pkg; drains tfd_queue and drives the result channel.
`default_nettype none

module tfd_back #(
   parameter int GRID_ROWS = 6,
   parameter int GRID_COLS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire tfd_pkg::q_status_type              q_status,
   input  wire tfd_pkg::wr_cmd_type                q_cmd,
   output      logic                               q_pop,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [tfd_pkg::WORD_W-1:0]         rsp_cell_value,
   output      logic [tfd_pkg::CELL_INDEX_W-1:0]   rsp_cell_index,
   output      logic                               rsp_last_cell
);

   localparam int CELLS  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

   logic [tfd_pkg::WORD_W-1:0] store_ff [CELLS];

   logic                       busy_ff, busy_in;
   logic [ADDR_W-1:0]          pos_ff, pos_in;
   logic [ADDR_W-1:0]          src_ff, src_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tfd_pkg::WORD_W-1:0] value_ff;
   logic [ADDR_W-1:0]          out_pos_ff;
   logic                       last_ff;
   logic                       issue;
   logic                       pos_last;

   assign q_pop    = !busy_ff && !q_status.empty;
   assign issue    = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign pos_last = (pos_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      src_in   = src_ff;
      base_in  = base_ff;
      col_in   = col_ff;
      if (q_pop && q_cmd.emit) begin
         busy_in = 1'b1;
         pos_in  = '0;
         src_in  = ADDR_W'(GRID_ROWS - 1);
         base_in = ADDR_W'(GRID_ROWS - 1);
         col_in  = '0;
      end else if (issue) begin
         pos_in = pos_ff + ADDR_W'(1);
         if (pos_last) begin
            busy_in = 1'b0;
         end
         // step one column right, or wrap to the next row up the store
         if (col_ff == COL_W'(GRID_COLS - 1)) begin
            col_in  = '0;
            base_in = base_ff - ADDR_W'(1);
            src_in  = base_ff - ADDR_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
            src_in = src_ff + ADDR_W'(GRID_ROWS);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff  <= pos_in;
      src_ff  <= src_in;
      base_ff <= base_in;
      col_ff  <= col_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         store_ff[q_cmd.addr[ADDR_W-1:0]] <= q_cmd.word;
      end
      if (issue) begin
         value_ff   <= store_ff[src_ff];
         out_pos_ff <= pos_ff;
         last_ff    <= pos_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = value_ff;
   assign rsp_cell_index = tfd_pkg::CELL_INDEX_W'(out_pos_ff);
   assign rsp_last_cell  = last_ff;

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !q_pop)
      else $error("store written during readout");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> out_pos_ff == ADDR_W'(CELLS - 1))
      else $error("last cell flagged at wrong position");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      issue && pos_last |=> !busy_ff && rsp_valid_ff)
      else $error("readout did not finish after final word");

   a_start_row: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_cmd.emit |=> busy_ff && pos_ff == '0 && col_ff == '0)
      else $error("readout did not start cleanly");

endmodule

`default_nettype wire

@@ hdl/touch_frame_deframer.sv @@
// Touch frame deframer top level: front end, command queue and back end.
// Depends on tfd_pkg, tfd_front, tfd_queue and tfd_back.
//
// The block takes one received UART byte per beat on the req_ channel. It
// hunts for the sync byte 0x12 and then waits for 0x34; a wrong byte while
// waiting does not restart the hunt. It then collects 2*GRID_ROWS*GRID_COLS
// bytes as little-endian 16-bit words. Once the last word of the frame is
// stored, it sends GRID_ROWS*GRID_COLS beats on the rsp_ channel in
// transposed order: beat i*GRID_COLS+j carries stored word
// (GRID_ROWS-1-i) + GRID_ROWS*j, rsp_cell_index gives that position (low five
// bits) and rsp_last_cell marks the final beat. Bytes are taken one per clock
// while the four-entry command queue has room; each pair of collected bytes
// makes one queue entry. The back end drains one entry per clock while it is
// not reading out and, after a frame's final entry, reads out one word per
// clock from its store while rsp_stall stays low. During a readout the queue
// absorbs up to eight more frame bytes before req_stall rises. The word store
// needs no clearing after reset: every word is written before it is read.
`default_nettype none

module touch_frame_deframer #(
   parameter int GRID_ROWS = 6,
   parameter int GRID_COLS = 4
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [tfd_pkg::BYTE_W-1:0]         req_rx_byte,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic [tfd_pkg::WORD_W-1:0]         rsp_cell_value,
   output      logic [tfd_pkg::CELL_INDEX_W-1:0]   rsp_cell_index,
   output      logic                               rsp_last_cell
);

   // commands from the front end into the queue
   tfd_pkg::wr_cmd_type   push_cmd;
   logic                  cmd_push;
   // queue head, seen by the back end, and occupancy, seen by both ends
   tfd_pkg::wr_cmd_type   head_cmd;
   tfd_pkg::q_status_type q_status;
   logic                  q_pop;

   // Hunt for sync, pair bytes into words, push one command per word.
   tfd_front #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .q_status    (q_status),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   // Hold word commands while the back end is busy reading out a frame.
   tfd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   // Store words, then advance through the transposed readout.
   tfd_back #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .q_cmd          (head_cmd),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cell_index (rsp_cell_index),
      .rsp_last_cell  (rsp_last_cell)
   );

endmodule

`default_nettype wire

@@ dv/touch_frame_deframer_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for touch_frame_deframer: directed byte table, then random frames.
// Depends on tfd_pkg and the touch_frame_deframer RTL; nothing else is read.

module touch_frame_deframer_test;

   localparam int ROWS         = 6;
   localparam int COLS         = 4;
   localparam int CELLS        = ROWS * COLS;
   localparam int FRAME_BYTES  = 2 * CELLS;
   localparam int RANDOM_ITEMS = 180;
   localparam int CALM_ITEMS   = 60;
   localparam int LONG_HOLD    = 400;
   localparam int WATCHDOG     = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_MAX   = 10;

   // Deframer phases, mirrored in the order the block walks them.
   typedef enum logic [1:0] {
      HUNT_FIRST  = 2'd0,
      WAIT_SECOND = 2'd1,
      COLLECT     = 2'd2
   } deframe_phase_type;

   // One expected or observed beat on the result channel.
   typedef struct packed {
      logic [tfd_pkg::WORD_W-1:0]       value;
      logic [tfd_pkg::CELL_INDEX_W-1:0] index;
      logic                             last;
   } cell_beat_type;

   // Directed rows: a single byte, a whole frame of one byte, or a ramp of 48 bytes.
   typedef enum logic [1:0] {
      ROW_BYTE = 2'd0,
      ROW_FILL = 2'd1,
      ROW_RAMP = 2'd2
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [tfd_pkg::BYTE_W-1:0] value;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 15;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_BYTE, 8'h00},                 // noise while hunting: dropped
      '{ROW_BYTE, 8'hFF},                 // noise while hunting: dropped
      '{ROW_BYTE, tfd_pkg::SYNC_SECOND},  // second sync while hunting: dropped
      '{ROW_BYTE, tfd_pkg::SYNC_FIRST},
      '{ROW_BYTE, 8'h00},                 // wrong byte while waiting: keep waiting
      '{ROW_BYTE, tfd_pkg::SYNC_FIRST},   // first sync again while waiting: keep waiting
      '{ROW_BYTE, 8'hFF},
      '{ROW_BYTE, tfd_pkg::SYNC_SECOND},
      '{ROW_FILL, 8'hFF},                 // every cell at the top of the range
      '{ROW_BYTE, tfd_pkg::SYNC_FIRST},
      '{ROW_BYTE, tfd_pkg::SYNC_SECOND},
      '{ROW_FILL, 8'h00},                 // every cell at zero
      '{ROW_BYTE, tfd_pkg::SYNC_FIRST},
      '{ROW_BYTE, tfd_pkg::SYNC_SECOND},
      '{ROW_RAMP, 8'h10}                  // distinct words expose the transpose
   };

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [tfd_pkg::BYTE_W-1:0]         req_rx_byte;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [tfd_pkg::WORD_W-1:0]         rsp_cell_value;
   logic [tfd_pkg::CELL_INDEX_W-1:0]   rsp_cell_index;
   logic                               rsp_last_cell;

   // Predictor state.
   deframe_phase_type          rx_phase = HUNT_FIRST;
   logic [5:0]                 rx_count = '0;
   logic [tfd_pkg::WORD_W-1:0] cell_words [CELLS];

   // Beats still owed by the block, oldest first.
   cell_beat_type pending_cells [$];
   // Frame words typed in by the directed table; one entry per fill frame.
   logic [tfd_pkg::WORD_W-1:0] quoted_fill_words [$];

   bit calm_tail         = 1'b0;
   bit long_hold_request = 1'b0;

   int mismatch_count     = 0;
   int bytes_accepted     = 0;
   int cells_checked      = 0;
   int frames_predicted   = 0;
   int input_stall_cycles = 0;
   int quiet_cycles       = 0;

   always #4 clock = ~clock;

   touch_frame_deframer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cell_index (rsp_cell_index),
      .rsp_last_cell  (rsp_last_cell)
   );

   // Advance the deframer by one accepted byte. On the last byte of a frame, queue
   // all cells in transposed order: position r*COLS+c carries word (ROWS-1-r)+ROWS*c.
   function automatic void deframe_byte(input logic [tfd_pkg::BYTE_W-1:0] rx);
      int                         pos;
      bit                         use_quote;
      logic [tfd_pkg::WORD_W-1:0] quote;
      cell_beat_type              beat;
      use_quote = 1'b0;
      quote     = '0;
      case (rx_phase)
         WAIT_SECOND: begin
            // a wrong byte leaves the phase alone; there is no fall back to hunting
            if (rx == tfd_pkg::SYNC_SECOND)
               rx_phase = COLLECT;
         end
         COLLECT: begin
            if (!rx_count[0])
               cell_words[rx_count[5:1]] = {8'h00, rx};
            else
               cell_words[rx_count[5:1]][15:8] = rx;
            if (rx_count == 6'(FRAME_BYTES - 1)) begin
               rx_count = '0;
               rx_phase = HUNT_FIRST;
               frames_predicted++;
               if (quoted_fill_words.size() != 0) begin
                  use_quote = 1'b1;
                  quote     = quoted_fill_words.pop_front();
               end
               for (int r = 0; r < ROWS; r++) begin
                  for (int c = 0; c < COLS; c++) begin
                     pos        = r * COLS + c;
                     beat.value = use_quote ? quote : cell_words[(ROWS - 1 - r) + ROWS * c];
                     beat.index = pos[tfd_pkg::CELL_INDEX_W-1:0];
                     beat.last  = (pos == CELLS - 1);
                     pending_cells.push_back(beat);
                  end
               end
            end else begin
               rx_count = rx_count + 6'd1;
            end
         end
         default: begin
            // hunting: anything but the first sync byte is dropped
            rx_phase = (rx == tfd_pkg::SYNC_FIRST) ? WAIT_SECOND : HUNT_FIRST;
         end
      endcase
   endfunction

   // Offer one byte and hold it until the block takes it. A random gap may come
   // first; valid drops only for the gap, so back-to-back beats keep it high.
   task automatic offer_byte(input logic [tfd_pkg::BYTE_W-1:0] rx);
      int gap;
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Predict and check on the same edge the block sees: inputs are sampled as they
   // stood before the edge, since all stimulus is driven with nonblocking updates.
   always @(posedge clock) begin : beat_monitor
      cell_beat_type got;
      cell_beat_type want;
      if (reset) begin
         rx_phase = HUNT_FIRST;
         rx_count = '0;
      end else begin
         if (req_valid && req_stall)
            input_stall_cycles++;
         if (req_valid && !req_stall) begin
            bytes_accepted++;
            deframe_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{value: rsp_cell_value, index: rsp_cell_index, last: rsp_last_cell};
            cells_checked++;
            if (pending_cells.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected cell beat: value %h index %0d last %0b",
                           got.value, got.index, got.last);
            end else begin
               want = pending_cells.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display({"cell mismatch: expected value %h index %0d last %0b,",
                               " got value %h index %0d last %0b"},
                              want.value, want.index, want.last,
                              got.value, got.index, got.last);
               end
            end
         end
      end
   end

   // Count cycles in which neither channel moves a beat; end the run if the block hangs.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
         $display("timeout: no beat accepted for %0d cycles", WATCHDOG);
         $display("touch_frame_deframer test failed");
         $finish;
      end
   end

   // Result side: random stall bursts, plus one long hold on request so that the
   // readout backs up, the command queue fills and req_stall rises.
   initial begin : result_side
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : byte_source
      int                         frame_items;
      int                         count;
      int                         style;
      logic [tfd_pkg::BYTE_W-1:0] rx;
      logic [tfd_pkg::BYTE_W-1:0] corners [4];

      corners     = '{8'h00, 8'hFF, tfd_pkg::SYNC_FIRST, tfd_pkg::SYNC_SECOND};
      frame_items = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Fill frames carry their expected word; the rest go to the predictor.
      foreach (directed_rows[k]) begin
         case (directed_rows[k].kind)
            ROW_FILL: begin
               quoted_fill_words.push_back({directed_rows[k].value, directed_rows[k].value});
               repeat (FRAME_BYTES) offer_byte(directed_rows[k].value);
            end
            ROW_RAMP: begin
               for (int n = 0; n < FRAME_BYTES; n++)
                  offer_byte(directed_rows[k].value + 8'(n));
            end
            default: offer_byte(directed_rows[k].value);
         endcase
      end

      // Random part: mostly well-formed frames with random payload, some line noise
      // before the header and some wrong bytes between the two sync bytes.
      long_hold_request = 1'b1;
      while (frame_items < RANDOM_ITEMS) begin
         if (frame_items >= RANDOM_ITEMS - CALM_ITEMS)
            calm_tail = 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, 3);
            repeat (count) offer_byte(8'($urandom));
         end
         offer_byte(tfd_pkg::SYNC_FIRST);
         frame_items++;
         if ($urandom_range(0, 4) == 0) begin
            count = $urandom_range(1, 2);
            repeat (count) begin
               rx = 8'($urandom);
               if (rx == tfd_pkg::SYNC_SECOND)
                  rx = ~rx;
               offer_byte(rx);
               frame_items++;
            end
         end
         offer_byte(tfd_pkg::SYNC_SECOND);
         frame_items++;
         style = $urandom_range(0, 3);
         repeat (FRAME_BYTES) begin
            rx = (style == 0) ? corners[$urandom_range(0, 3)] : 8'($urandom);
            offer_byte(rx);
            frame_items++;
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed beat, then watch a while for stray ones.
      while (pending_cells.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input bytes over %0d frames, %0d cell beats compared",
               bytes_accepted, frames_predicted, cells_checked);
      $display("input held off for %0d cycles; %0d mismatches",
               input_stall_cycles, mismatch_count);
      if (mismatch_count == 0)
         $display("touch_frame_deframer test passed");
      else
         $display("touch_frame_deframer test failed");
      $finish;
   end

endmodule

@@ touch_frame_deframer.f @@
hdl/tfd_pkg.sv
hdl/tfd_front.sv
hdl/tfd_queue.sv
hdl/tfd_back.sv
hdl/touch_frame_deframer.sv
dv/touch_frame_deframer_test.sv
